### hw/rtl/vfc_pkg.sv
`default_nettype none

package vfc_pkg;

    // Default geometry of the occupancy column.
    localparam int GRID_SIDE_DEF     = 16;
    localparam int SUBGRID_COUNT_DEF = 16;

    // Field widths of the ports.
    localparam int POS_W        = 16;
    localparam int COORD_W      = 17;
    localparam int VERT_W       = 18;
    localparam int CFG_IDX_W    = 2;
    localparam int FACE_W       = 3;
    localparam int CORNER_W     = 2;
    localparam int FACE_COUNT   = 6;
    localparam int CORNER_STEPS = 6;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_VERTEX   = 2'd0,
        STAT_SET_DONE = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_RANGE    = 2'd3
    } status_t;

    // Face identifiers, in emission order.
    typedef enum logic [2:0] {
        FACE_WEST   = 3'd0,
        FACE_EAST   = 3'd1,
        FACE_BOTTOM = 3'd2,
        FACE_TOP    = 3'd3,
        FACE_SOUTH  = 3'd4,
        FACE_NORTH  = 3'd5
    } face_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_CHUNK_X = 2'd0,
        CFG_CHUNK_Y = 2'd1,
        CFG_CHUNK_Z = 2'd2
    } cfg_reg_t;

    // Control sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_LOCATE,
        ST_SET_READ,
        ST_SET_WRITE,
        ST_FETCH,
        ST_SETTLE,
        ST_OPEN,
        ST_EMIT
    } state_t;

    // Occupancy rows fetched for an emit request.
    typedef enum logic [2:0] {
        SLOT_CENTER,
        SLOT_WEST,
        SLOT_EAST,
        SLOT_BOTTOM,
        SLOT_TOP
    } slot_t;

    // Corner offsets {x, y, z} for each face and quad corner.
    localparam logic [2:0] FACE_CORNER [FACE_COUNT][4] = '{
        '{3'b010, 3'b000, 3'b001, 3'b011},
        '{3'b111, 3'b101, 3'b100, 3'b110},
        '{3'b001, 3'b000, 3'b100, 3'b101},
        '{3'b010, 3'b011, 3'b111, 3'b110},
        '{3'b110, 3'b100, 3'b000, 3'b010},
        '{3'b011, 3'b001, 3'b101, 3'b111}
    };

    // Quad corner visited at each of the six vertex steps of a face.
    localparam logic [1:0] CORNER_SEQ [CORNER_STEPS] = '{
        2'd0, 2'd1, 2'd2, 2'd2, 2'd3, 2'd0
    };

    // Lowest face whose bit is set in the mask.
    function automatic face_t lowest_face(input logic [FACE_COUNT-1:0] mask);
        face_t f;
        f = FACE_WEST;
        for (int i = FACE_COUNT - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                f = face_t'(3'(i));
            end
        end
        return f;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/vfc_ram.sv
`default_nettype none

module vfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/voxel_face_cull_mesher_core.sv
`default_nettype none

// Channel    | Handshake              | Payload
// -----------+------------------------+--------------------------------------------------
// request    | start, busy            | func, cube_x, cube_y, cube_z
// config     | cfg_valid, cfg_ready   | cfg_index, cfg_data
// result     | done (one-cycle pulse) | status, vert_x, vert_y, vert_z, face_id,
//            |                        | corner_index, last
//
// After reset the block sweeps the occupancy RAM, one row a cycle, over all
// SUBGRID_COUNT * GRID_SIDE^2 rows (4096 at default size) with busy high.
// A set request runs decode, locate, a row read and a row write; an out-of-range
// request ends at decode. An emit runs decode, locate, five row reads over the single
// RAM read port, settle and face check, then one vertex per cycle, up to 36 vertices.
// Results are not stalled: each appears for exactly one cycle with done high.
// Config writes are taken in any cycle (cfg_ready is always high).
module voxel_face_cull_mesher_core #(
    parameter int GRID_SIDE     = vfc_pkg::GRID_SIDE_DEF,
    parameter int SUBGRID_COUNT = vfc_pkg::SUBGRID_COUNT_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 func,
    input  wire logic signed [vfc_pkg::COORD_W-1:0]   cube_x,
    input  wire logic signed [vfc_pkg::COORD_W-1:0]   cube_y,
    input  wire logic signed [vfc_pkg::COORD_W-1:0]   cube_z,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic        [vfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic signed [vfc_pkg::POS_W-1:0]     cfg_data,
    output logic                                      done,
    output logic             [1:0]                    status,
    output logic signed      [vfc_pkg::VERT_W-1:0]    vert_x,
    output logic signed      [vfc_pkg::VERT_W-1:0]    vert_y,
    output logic signed      [vfc_pkg::VERT_W-1:0]    vert_z,
    output logic             [vfc_pkg::FACE_W-1:0]    face_id,
    output logic             [vfc_pkg::CORNER_W-1:0]  corner_index,
    output logic                                      last
);

    localparam int G     = GRID_SIDE;
    localparam int GW    = $clog2(G);
    localparam int ROWS  = SUBGRID_COUNT * G;
    localparam int YW    = $clog2(ROWS);
    localparam int DEPTH = ROWS * G;
    localparam int AW    = $clog2(DEPTH);
    localparam int VW    = vfc_pkg::VERT_W;
    localparam int CW    = vfc_pkg::COORD_W;
    localparam int PSW   = vfc_pkg::POS_W;
    localparam int FC    = vfc_pkg::FACE_COUNT;
    // Reciprocal of GRID_SIDE for the row-in-subgrid split of cube_y.
    localparam int RK    = YW + GW;
    localparam int RECIP = (2 ** RK + G - 1) / G;
    localparam int RW    = RK + 1;
    localparam int PW    = YW + RW;

    // Control state.
    vfc_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;
    vfc_pkg::slot_t  fetch_reg, fetch_next;
    logic            rd_pend_reg;
    vfc_pkg::slot_t  rd_slot_reg;
    logic            done_reg, done_next;

    // Chunk position registers.
    logic signed [PSW-1:0] pos_x_reg, pos_y_reg, pos_z_reg;

    // Request and decoded geometry.
    logic                 func_reg, func_next;
    logic signed [CW-1:0] wx_reg, wx_next, wy_reg, wy_next, wz_reg, wz_next;
    logic [GW-1:0]        lx_reg, lx_next, lz_reg, lz_next;
    logic [YW-1:0]        wy_t_reg, wy_t_next;
    logic [PW-1:0]        prod_reg, prod_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic                 ly_first_reg, ly_first_next, ly_last_reg, ly_last_next;

    // Fetched occupancy rows and face walk.
    logic [G-1:0]         center_reg, west_reg, east_reg, bottom_reg, top_reg;
    logic [FC-1:0]        mask_reg, mask_next;
    vfc_pkg::face_t       face_reg, face_next;
    logic [2:0]           step_reg, step_next;

    // Result registers.
    vfc_pkg::status_t     status_reg, status_next;
    logic signed [VW-1:0] vx_reg, vx_next, vy_reg, vy_next, vz_reg, vz_next;
    logic [2:0]           face_id_reg, face_id_next;
    logic [1:0]           corner_reg, corner_next;
    logic                 last_reg, last_next;

    // RAM port signals.
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [G-1:0]  ram_wdata, ram_rdata;

    // Datapath helpers.
    logic signed [VW-1:0] lx_full, lz_full;
    logic                 lx_ok, lz_ok, wy_ok;
    logic [YW-1:0]        quot;
    logic [YW:0]          ly_raw, ly_val;
    logic                 lx_first, lx_last, lz_first, lz_last;
    logic                 center_bit, south_bit, north_bit;
    logic [FC-1:0]        mask_now, above, mask_rest;
    logic [1:0]           quad;
    logic [2:0]           offs;

    // Occupancy RAM: one row of GRID_SIDE cubes along z per word.
    vfc_ram #(
        .WIDTH (G),
        .DEPTH (DEPTH)
    ) u_occ_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Local coordinates and range checks.
    always_comb
    begin
        lx_full = {wx_reg[CW-1], wx_reg} - {{(VW-PSW){pos_x_reg[PSW-1]}}, pos_x_reg};
        lz_full = {wz_reg[CW-1], wz_reg} - {{(VW-PSW){pos_z_reg[PSW-1]}}, pos_z_reg};
        lx_ok   = !lx_full[VW-1] && (lx_full[VW-2:0] < (VW-1)'(G));
        lz_ok   = !lz_full[VW-1] && (lz_full[VW-2:0] < (VW-1)'(G));
        wy_ok   = !wy_reg[CW-1] && (wy_reg[CW-2:0] < (CW-1)'(ROWS));
    end

    // Row within the subgrid from the reciprocal product, with one correction step.
    always_comb
    begin
        quot   = YW'(prod_reg >> RK);
        ly_raw = {1'b0, wy_t_reg} - ((YW+1)'(quot) * (YW+1)'(G));
        ly_val = (ly_raw >= (YW+1)'(G)) ? (ly_raw - (YW+1)'(G)) : ly_raw;
    end

    // Exposed-face mask from the fetched rows.
    always_comb
    begin
        lx_first   = (lx_reg == '0);
        lx_last    = (lx_reg == GW'(G - 1));
        lz_first   = (lz_reg == '0);
        lz_last    = (lz_reg == GW'(G - 1));
        center_bit = center_reg[lz_reg];
        south_bit  = lz_first ? 1'b0 : center_reg[lz_reg - GW'(1)];
        north_bit  = lz_last ? 1'b0 : center_reg[lz_reg + GW'(1)];
        mask_now[vfc_pkg::FACE_WEST]   = lx_first || !west_reg[lz_reg];
        mask_now[vfc_pkg::FACE_EAST]   = lx_last || !east_reg[lz_reg];
        mask_now[vfc_pkg::FACE_BOTTOM] = ly_first_reg || !bottom_reg[lz_reg];
        mask_now[vfc_pkg::FACE_TOP]    = ly_last_reg || !top_reg[lz_reg];
        mask_now[vfc_pkg::FACE_SOUTH]  = !south_bit;
        mask_now[vfc_pkg::FACE_NORTH]  = !north_bit;
    end

    // Faces still to emit after the current one.
    always_comb
    begin
        for (int i = 0; i < FC; i++)
        begin
            above[i] = (3'(i) > face_reg);
        end
        mask_rest = mask_reg & above;
        quad      = vfc_pkg::CORNER_SEQ[step_reg];
        offs      = vfc_pkg::FACE_CORNER[face_reg][quad];
    end

    // Sequencer: next state, datapath loads, RAM control and results.
    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        fetch_next    = fetch_reg;
        func_next     = func_reg;
        wx_next       = wx_reg;
        wy_next       = wy_reg;
        wz_next       = wz_reg;
        lx_next       = lx_reg;
        lz_next       = lz_reg;
        wy_t_next     = wy_t_reg;
        prod_next     = prod_reg;
        addr_next     = addr_reg;
        ly_first_next = ly_first_reg;
        ly_last_next  = ly_last_reg;
        mask_next     = mask_reg;
        face_next     = face_reg;
        step_next     = step_reg;
        done_next     = 1'b0;
        status_next   = vfc_pkg::STAT_VERTEX;
        vx_next       = '0;
        vy_next       = '0;
        vz_next       = '0;
        face_id_next  = '0;
        corner_next   = '0;
        last_next     = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = clr_reg;
        ram_wdata     = '0;
        ram_raddr     = addr_reg;

        unique case (state_reg)
            vfc_pkg::ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = vfc_pkg::ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end

            vfc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    func_next  = func;
                    wx_next    = cube_x;
                    wy_next    = cube_y;
                    wz_next    = cube_z;
                    state_next = vfc_pkg::ST_DECODE;
                end
            end

            vfc_pkg::ST_DECODE:
            begin
                if (lx_ok && lz_ok && wy_ok)
                begin
                    lx_next    = lx_full[GW-1:0];
                    lz_next    = lz_full[GW-1:0];
                    wy_t_next  = wy_reg[YW-1:0];
                    prod_next  = PW'(wy_reg[YW-1:0]) * PW'(RECIP);
                    state_next = vfc_pkg::ST_LOCATE;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = vfc_pkg::STAT_RANGE;
                    last_next   = 1'b1;
                    state_next  = vfc_pkg::ST_IDLE;
                end
            end

            vfc_pkg::ST_LOCATE:
            begin
                addr_next     = (AW'(wy_t_reg) * AW'(G)) + AW'(lx_reg);
                ly_first_next = (ly_val == '0);
                ly_last_next  = (ly_val == (YW+1)'(G - 1));
                fetch_next    = vfc_pkg::SLOT_CENTER;
                state_next    = func_reg ? vfc_pkg::ST_FETCH : vfc_pkg::ST_SET_READ;
            end

            vfc_pkg::ST_SET_READ:
            begin
                state_next = vfc_pkg::ST_SET_WRITE;
            end

            vfc_pkg::ST_SET_WRITE:
            begin
                ram_we      = 1'b1;
                ram_waddr   = addr_reg;
                ram_wdata   = ram_rdata | (G'(1) << lz_reg);
                done_next   = 1'b1;
                status_next = vfc_pkg::STAT_SET_DONE;
                last_next   = 1'b1;
                state_next  = vfc_pkg::ST_IDLE;
            end

            vfc_pkg::ST_FETCH:
            begin
                // Neighbors outside the subgrid re-read the center row; their bit is masked.
                case (fetch_reg)
                    vfc_pkg::SLOT_WEST:   ram_raddr = lx_first ? addr_reg : addr_reg - AW'(1);
                    vfc_pkg::SLOT_EAST:   ram_raddr = lx_last ? addr_reg : addr_reg + AW'(1);
                    vfc_pkg::SLOT_BOTTOM: ram_raddr = ly_first_reg ? addr_reg : addr_reg - AW'(G);
                    vfc_pkg::SLOT_TOP:    ram_raddr = ly_last_reg ? addr_reg : addr_reg + AW'(G);
                    default:              ram_raddr = addr_reg;
                endcase
                if (fetch_reg == vfc_pkg::SLOT_TOP)
                begin
                    state_next = vfc_pkg::ST_SETTLE;
                end
                else
                begin
                    fetch_next = vfc_pkg::slot_t'(3'(fetch_reg + 3'd1));
                end
            end

            vfc_pkg::ST_SETTLE:
            begin
                state_next = vfc_pkg::ST_OPEN;
            end

            vfc_pkg::ST_OPEN:
            begin
                if (!center_bit || (mask_now == '0))
                begin
                    done_next   = 1'b1;
                    status_next = vfc_pkg::STAT_EMPTY;
                    last_next   = 1'b1;
                    state_next  = vfc_pkg::ST_IDLE;
                end
                else
                begin
                    mask_next  = mask_now;
                    face_next  = vfc_pkg::lowest_face(mask_now);
                    step_next  = '0;
                    state_next = vfc_pkg::ST_EMIT;
                end
            end

            vfc_pkg::ST_EMIT:
            begin
                done_next    = 1'b1;
                status_next  = vfc_pkg::STAT_VERTEX;
                vx_next      = {wx_reg[CW-1], wx_reg} + VW'(offs[2]);
                vy_next      = {{(VW-PSW){pos_y_reg[PSW-1]}}, pos_y_reg}
                             + {wy_reg[CW-1], wy_reg} + VW'(offs[1]);
                vz_next      = {wz_reg[CW-1], wz_reg} + VW'(offs[0]);
                face_id_next = face_reg;
                corner_next  = quad;
                if (step_reg == 3'(vfc_pkg::CORNER_STEPS - 1))
                begin
                    step_next = '0;
                    if (mask_rest == '0)
                    begin
                        last_next  = 1'b1;
                        state_next = vfc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        face_next = vfc_pkg::lowest_face(mask_rest);
                    end
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end

            default:
            begin
                state_next = vfc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= vfc_pkg::ST_CLEAR;
            clr_reg     <= '0;
            fetch_reg   <= vfc_pkg::SLOT_CENTER;
            rd_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            fetch_reg   <= fetch_next;
            rd_pend_reg <= (state_reg == vfc_pkg::ST_FETCH);
            done_reg    <= done_next;
        end
    end

    // Chunk position registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                vfc_pkg::CFG_CHUNK_X: pos_x_reg <= cfg_data;
                vfc_pkg::CFG_CHUNK_Y: pos_y_reg <= cfg_data;
                vfc_pkg::CFG_CHUNK_Z: pos_z_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        wx_reg       <= wx_next;
        wy_reg       <= wy_next;
        wz_reg       <= wz_next;
        lx_reg       <= lx_next;
        lz_reg       <= lz_next;
        wy_t_reg     <= wy_t_next;
        prod_reg     <= prod_next;
        addr_reg     <= addr_next;
        ly_first_reg <= ly_first_next;
        ly_last_reg  <= ly_last_next;
        mask_reg     <= mask_next;
        face_reg     <= face_next;
        step_reg     <= step_next;
        status_reg   <= status_next;
        vx_reg       <= vx_next;
        vy_reg       <= vy_next;
        vz_reg       <= vz_next;
        face_id_reg  <= face_id_next;
        corner_reg   <= corner_next;
        last_reg     <= last_next;
        rd_slot_reg  <= fetch_reg;
    end

    // Capture each fetched row from the registered RAM output in the cycle after its read was issued.
    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            case (rd_slot_reg)
                vfc_pkg::SLOT_CENTER: center_reg <= ram_rdata;
                vfc_pkg::SLOT_WEST:   west_reg   <= ram_rdata;
                vfc_pkg::SLOT_EAST:   east_reg   <= ram_rdata;
                vfc_pkg::SLOT_BOTTOM: bottom_reg <= ram_rdata;
                vfc_pkg::SLOT_TOP:    top_reg    <= ram_rdata;
                default:
                begin
                end
            endcase
        end
    end

    assign busy         = (state_reg != vfc_pkg::ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign done         = done_reg;
    assign status       = status_reg;
    assign vert_x       = vx_reg;
    assign vert_y       = vy_reg;
    assign vert_z       = vz_reg;
    assign face_id      = face_id_reg;
    assign corner_index = corner_reg;
    assign last         = last_reg;

    // A result that is not a vertex is always the only result of its request.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg != vfc_pkg::STAT_VERTEX)) |-> last_reg)
        else $error("non-vertex result without last");

    // The face being walked is always one of the exposed faces.
    a_emit_open_face: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vfc_pkg::ST_EMIT) |-> mask_reg[face_reg])
        else $error("emitting a hidden face");

    // An accepted request keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // The occupancy RAM is written only by the clearing sweep or a set request.
    a_write_scope: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == vfc_pkg::ST_CLEAR) || (state_reg == vfc_pkg::ST_SET_WRITE)))
        else $error("unexpected occupancy write");

endmodule

`default_nettype wire

### dv/voxel_face_cull_mesher_core_test.sv
`default_nettype none

module voxel_face_cull_mesher_core_test;

    import vfc_pkg::*;

    localparam int SIDE     = GRID_SIDE_DEF;
    localparam int SUBGRIDS = SUBGRID_COUNT_DEF;
    localparam int COLUMN_H = SIDE * SUBGRIDS;
    localparam int CELLS    = SUBGRIDS * SIDE * SIDE * SIDE;

    // Request function codes.
    localparam logic FN_SET  = 1'b0;
    localparam logic FN_EMIT = 1'b1;

    localparam int PHASES = 7;

    // One result as seen on the result ports.
    typedef struct {
        status_t                  status;
        logic signed [VERT_W-1:0] vx;
        logic signed [VERT_W-1:0] vy;
        logic signed [VERT_W-1:0] vz;
        face_t                    face;
        logic [CORNER_W-1:0]      corner;
        logic                     last;
    } mesh_result_t;

    // Mesher scoreboard: tracks occupancy and chunk position, predicts the
    // results of each accepted request and checks them in order.
    class mesh_scoreboard;
        bit                      solid_map [0:CELLS-1];
        logic signed [POS_W-1:0] chunk_x;
        logic signed [POS_W-1:0] chunk_y;
        logic signed [POS_W-1:0] chunk_z;
        mesh_result_t            due_q [$];
        bit [2:0]                corner_ofs [FACE_COUNT][4];
        int                      quad_step [CORNER_STEPS];
        int                      errors;
        int                      requests;
        int                      sets;
        int                      rejects;
        int                      blanks;
        int                      vertices;

        function new();
            // Corner offsets are {x, y, z} per face and quad corner.
            corner_ofs = '{
                '{3'b010, 3'b000, 3'b001, 3'b011},
                '{3'b111, 3'b101, 3'b100, 3'b110},
                '{3'b001, 3'b000, 3'b100, 3'b101},
                '{3'b010, 3'b011, 3'b111, 3'b110},
                '{3'b110, 3'b100, 3'b000, 3'b010},
                '{3'b011, 3'b001, 3'b101, 3'b111}
            };
            quad_step = '{0, 1, 2, 2, 3, 0};
            chunk_x   = '0;
            chunk_y   = '0;
            chunk_z   = '0;
            errors    = 0;
            requests  = 0;
            sets      = 0;
            rejects   = 0;
            blanks    = 0;
            vertices  = 0;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function void set_chunk(cfg_reg_t idx, logic signed [POS_W-1:0] value);
            case (idx)
                CFG_CHUNK_X: chunk_x = value;
                CFG_CHUNK_Y: chunk_y = value;
                CFG_CHUNK_Z: chunk_z = value;
                default:     ;
            endcase
        endfunction

        function int cell_at(int sub, int x, int y, int z);
            return ((sub * SIDE + y) * SIDE + x) * SIDE + z;
        endfunction

        // Neighbors outside the sub-grid never hide a face.
        function bit is_solid(int sub, int x, int y, int z);
            if (x < 0 || x >= SIDE || y < 0 || y >= SIDE || z < 0 || z >= SIDE)
            begin
                return 1'b0;
            end
            return solid_map[cell_at(sub, x, y, z)];
        endfunction

        function void push_result(status_t st, int vx, int vy, int vz, face_t face,
                                  int corner);
            mesh_result_t r;
            r.status = st;
            r.vx     = VERT_W'(vx);
            r.vy     = VERT_W'(vy);
            r.vz     = VERT_W'(vz);
            r.face   = face;
            r.corner = CORNER_W'(corner);
            r.last   = (st != STAT_VERTEX);
            due_q    = {due_q, r};
        endfunction

        // Work out the results of one accepted request.
        function void note_request(logic fn, logic signed [COORD_W-1:0] wx,
                                   logic signed [COORD_W-1:0] wy,
                                   logic signed [COORD_W-1:0] wz);
            int px;
            int py;
            int pz;
            int lx;
            int ly;
            int lz;
            int wy_i;
            int sub;
            int n;
            int q;
            int dx;
            int dy;
            int dz;
            bit exposed [FACE_COUNT];
            requests++;
            px   = chunk_x;
            py   = chunk_y;
            pz   = chunk_z;
            wy_i = wy;
            lx   = int'(wx) - px;
            lz   = int'(wz) - pz;

            if (wy_i < 0 || lx < 0 || lx >= SIDE || lz < 0 || lz >= SIDE ||
                wy_i / SIDE >= SUBGRIDS)
            begin
                rejects++;
                push_result(STAT_RANGE, 0, 0, 0, FACE_WEST, 0);
                return;
            end
            sub = wy_i / SIDE;
            ly  = wy_i % SIDE;

            if (fn == FN_SET)
            begin
                sets++;
                solid_map[cell_at(sub, lx, ly, lz)] = 1'b1;
                push_result(STAT_SET_DONE, 0, 0, 0, FACE_WEST, 0);
                return;
            end

            if (!solid_map[cell_at(sub, lx, ly, lz)])
            begin
                blanks++;
                push_result(STAT_EMPTY, 0, 0, 0, FACE_WEST, 0);
                return;
            end

            exposed[FACE_WEST]   = !is_solid(sub, lx - 1, ly, lz);
            exposed[FACE_EAST]   = !is_solid(sub, lx + 1, ly, lz);
            exposed[FACE_BOTTOM] = !is_solid(sub, lx, ly - 1, lz);
            exposed[FACE_TOP]    = !is_solid(sub, lx, ly + 1, lz);
            exposed[FACE_SOUTH]  = !is_solid(sub, lx, ly, lz - 1);
            exposed[FACE_NORTH]  = !is_solid(sub, lx, ly, lz + 1);

            // Two triangles per exposed face, in face order.
            n = 0;
            for (int f = 0; f < FACE_COUNT; f++)
            begin
                if (exposed[f])
                begin
                    for (int s = 0; s < CORNER_STEPS; s++)
                    begin
                        q  = quad_step[s];
                        dx = corner_ofs[f][q][2];
                        dy = corner_ofs[f][q][1];
                        dz = corner_ofs[f][q][0];
                        push_result(STAT_VERTEX, px + lx + dx, py + wy_i + dy,
                                    pz + lz + dz, face_t'(f), q);
                        n++;
                    end
                end
            end

            if (n == 0)
            begin
                blanks++;
                push_result(STAT_EMPTY, 0, 0, 0, FACE_WEST, 0);
            end
            else
            begin
                vertices += n;
                due_q[due_q.size() - 1].last = 1'b1;
            end
        endfunction

        task report_mismatch(input string what);
            errors++;
            if (errors <= 40)
            begin
                $display("tb: mismatch at %0t: %s", $time, what);
            end
        endtask

        // Compare one observed result with the oldest expectation.
        task check_result(input mesh_result_t got);
            mesh_result_t want;
            string        diffs;
            if (due_q.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending, status %0d",
                                          got.status));
                return;
            end
            want  = due_q.pop_front();
            diffs = "";
            if (got.status !== want.status)
                diffs = {diffs, $sformatf(" status %0d/%0d", got.status, want.status)};
            if (got.vx !== want.vx)
                diffs = {diffs, $sformatf(" vert_x %0d/%0d", got.vx, want.vx)};
            if (got.vy !== want.vy)
                diffs = {diffs, $sformatf(" vert_y %0d/%0d", got.vy, want.vy)};
            if (got.vz !== want.vz)
                diffs = {diffs, $sformatf(" vert_z %0d/%0d", got.vz, want.vz)};
            if (got.face !== want.face)
                diffs = {diffs, $sformatf(" face_id %0d/%0d", got.face, want.face)};
            if (got.corner !== want.corner)
                diffs = {diffs, $sformatf(" corner %0d/%0d", got.corner, want.corner)};
            if (got.last !== want.last)
                diffs = {diffs, $sformatf(" last %0d/%0d", got.last, want.last)};
            if (diffs != "")
            begin
                report_mismatch({"got/want:", diffs});
            end
        endtask
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic                         func;
    logic signed [COORD_W-1:0]    cube_x;
    logic signed [COORD_W-1:0]    cube_y;
    logic signed [COORD_W-1:0]    cube_z;
    logic                         cfg_valid;
    logic                         cfg_ready;
    cfg_reg_t                     cfg_index;
    logic signed [POS_W-1:0]      cfg_data;
    logic                         done;
    logic [1:0]                   status;
    logic signed [VERT_W-1:0]     vert_x;
    logic signed [VERT_W-1:0]     vert_y;
    logic signed [VERT_W-1:0]     vert_z;
    logic [FACE_W-1:0]            face_id;
    logic [CORNER_W-1:0]          corner_index;
    logic                         last;

    mesh_scoreboard sb;

    voxel_face_cull_mesher_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .cube_x       (cube_x),
        .cube_y       (cube_y),
        .cube_z       (cube_z),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .status       (status),
        .vert_x       (vert_x),
        .vert_y       (vert_y),
        .vert_z       (vert_z),
        .face_id      (face_id),
        .corner_index (corner_index),
        .last         (last)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // Result monitor: every done pulse is a result.
    always @(posedge clk)
    begin
        mesh_result_t seen;
        if (rst_n && done)
        begin
            seen.status = status_t'(status);
            seen.vx     = vert_x;
            seen.vy     = vert_y;
            seen.vz     = vert_z;
            seen.face   = face_t'(face_id);
            seen.corner = corner_index;
            seen.last   = last;
            sb.check_result(seen);
        end
    end

    // Present one request and hold it until the block takes it.
    task automatic send_request(input logic fn, input int wx, input int wy, input int wz);
        start  <= 1'b1;
        func   <= fn;
        cube_x <= COORD_W'(wx);
        cube_y <= COORD_W'(wy);
        cube_z <= COORD_W'(wz);
        do @(posedge clk); while (busy);
        sb.note_request(fn, COORD_W'(wx), COORD_W'(wy), COORD_W'(wz));
        @(negedge clk);
    endtask

    // Request addressed by chunk-local x and z.
    task automatic send_local(input logic fn, input int lx, input int wy, input int lz);
        send_request(fn, lx + sb.chunk_x, wy, lz + sb.chunk_z);
    endtask

    // Wait for every expected result, and optionally for the block to go idle.
    task automatic drain(input bit until_idle);
        while (sb.pending() != 0 || (until_idle && busy))
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= POS_W'(value);
        do @(posedge clk); while (!cfg_ready);
        sb.set_chunk(idx, POS_W'(value));
        @(negedge clk);
    endtask

    task automatic write_chunk(input int px, input int py, input int pz);
        write_reg(CFG_CHUNK_X, px);
        write_reg(CFG_CHUNK_Y, py);
        write_reg(CFG_CHUNK_Z, pz);
        cfg_valid <= 1'b0;
    endtask

    // Sender idling after a request: a full drain now and then, else a short burst.
    task automatic pause_after(input bit idle_ok);
        if (idle_ok && $urandom_range(0, 59) == 0)
        begin
            start <= 1'b0;
            drain(1'b0);
        end
        else if (idle_ok && $urandom_range(0, 2) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    endtask

    // Corners of the column, every range check, an enclosed cube and a
    // sub-grid boundary.
    task automatic directed_checks();
        send_local(FN_EMIT, 0, 0, 0);
        send_local(FN_SET, 0, 0, 0);
        send_local(FN_EMIT, 0, 0, 0);
        send_local(FN_SET, SIDE - 1, COLUMN_H - 1, SIDE - 1);
        send_local(FN_EMIT, SIDE - 1, COLUMN_H - 1, SIDE - 1);

        // Just outside on each axis, then the coordinate extremes.
        send_local(FN_SET, 0, -1, 0);
        send_local(FN_EMIT, 0, COLUMN_H, 0);
        send_local(FN_SET, -1, 0, 0);
        send_local(FN_EMIT, SIDE, 0, 0);
        send_local(FN_SET, 0, 0, -1);
        send_local(FN_EMIT, 0, 0, SIDE);
        send_request(FN_SET, -65536, 65535, -65536);
        send_request(FN_EMIT, 65535, -65536, 65535);

        // A cube with all six neighbors solid shows nothing.
        send_local(FN_SET, 5, 20, 5);
        send_local(FN_SET, 4, 20, 5);
        send_local(FN_SET, 6, 20, 5);
        send_local(FN_SET, 5, 19, 5);
        send_local(FN_SET, 5, 21, 5);
        send_local(FN_SET, 5, 20, 4);
        send_local(FN_SET, 5, 20, 6);
        send_local(FN_EMIT, 5, 20, 5);
        send_local(FN_EMIT, 4, 20, 5);

        // A solid cube across a sub-grid boundary does not hide the face.
        send_local(FN_SET, 8, SIDE - 1, 8);
        send_local(FN_SET, 8, SIDE, 8);
        send_local(FN_EMIT, 8, SIDE - 1, 8);
    endtask

    // Mostly in-range requests, many packed into a small cluster so that
    // neighbors hide faces; the rest just out of range or pure noise.
    task automatic random_phase(input int count, input bit idle_ok);
        int   cx;
        int   cy;
        int   cz;
        int   lx;
        int   wy;
        int   lz;
        int   pick;
        logic fn;
        cx = $urandom_range(0, SIDE - 4);
        cy = $urandom_range(0, COLUMN_H - 4);
        cz = $urandom_range(0, SIDE - 4);
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            fn   = ($urandom_range(0, 99) < 45) ? FN_SET : FN_EMIT;
            if (pick < 10)
            begin
                send_request(fn, $urandom, $urandom, $urandom);
            end
            else
            begin
                if (pick < 60)
                begin
                    lx = cx + $urandom_range(0, 3);
                    wy = cy + $urandom_range(0, 3);
                    lz = cz + $urandom_range(0, 3);
                end
                else
                begin
                    lx = $urandom_range(0, SIDE - 1);
                    wy = $urandom_range(0, COLUMN_H - 1);
                    lz = $urandom_range(0, SIDE - 1);
                end
                if (pick < 18)
                begin
                    case ($urandom_range(0, 5))
                        0:       lx = -1;
                        1:       lx = SIDE;
                        2:       lz = -1;
                        3:       lz = SIDE;
                        4:       wy = -1;
                        default: wy = COLUMN_H;
                    endcase
                end
                send_local(fn, lx, wy, lz);
            end
            pause_after(idle_ok);
        end
    endtask

    // Main sequence.
    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        func      = FN_SET;
        cube_x    = '0;
        cube_y    = '0;
        cube_z    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CHUNK_X;
        cfg_data  = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Let the occupancy clearing sweep finish.
        @(posedge clk);
        drain(1'b1);

        directed_checks();
        start <= 1'b0;
        drain(1'b1);

        // Chunk positions: both extremes, random ones, then back to zero.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       write_chunk(-32768, 32767, -32768);
                1:       write_chunk(32767, -32768, 32767);
                PHASES - 1: write_chunk(0, 0, 0);
                default: write_chunk($urandom, $urandom, $urandom);
            endcase
            random_phase(60, p != PHASES - 1);
            start <= 1'b0;
            drain(1'b1);
        end

        repeat (60) @(posedge clk);

        $display("tb: %0d requests: %0d sets, %0d out of range, %0d showing no face, %0d vertices",
                 sb.requests, sb.sets, sb.rejects, sb.blanks, sb.vertices);
        $display("tb: chunk position at reset value, both extremes and %0d random settings",
                 PHASES - 3);
        if (sb.errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
hw/rtl/vfc_pkg.sv
hw/rtl/vfc_ram.sv
hw/rtl/voxel_face_cull_mesher_core.sv
dv/voxel_face_cull_mesher_core_test.sv
